// ----- rtl/drt_pkg.sv -----
// shared types and constants for the dirty rectangle tracker
// used by the channel interfaces, the list sequencer and the top level
package drt_pkg;

	// field widths of the channels and configuration port
	localparam int COORD_IN_BITS = 16;
	localparam int OUT_POS_BITS  = 12;
	localparam int OUT_DIM_BITS  = 13;
	localparam int OUT_CNT_BITS  = 5;
	localparam int CFG_DIM_BITS  = 13;
	localparam int PCT_BITS      = 7;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_ADDR_BITS = 2;
	// widest internal coordinate value, covers any coordinate width in range
	localparam int WIDE_BITS     = 17;
	localparam int PCT_SCALE     = 100;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_SCREEN_WIDTH   = 2'd0,
		REG_SCREEN_HEIGHT  = 2'd1,
		REG_REDRAW_PERCENT = 2'd2
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_MARK  = 1'b0,
		KIND_FLUSH = 1'b1
	} item_kind_t;

	// list sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_CI,
		S_CI_LD,
		S_CJ,
		S_CJ_CHK,
		S_SH,
		S_SH_WR,
		S_AR,
		S_AR_MUL,
		S_AR_ACC,
		S_THR,
		S_THR2,
		S_CMP,
		S_RESP,
		S_FLUSH,
		S_FL_RD,
		S_FL_OUT
	} seq_state_t;

endpackage

// ----- rtl/drt_if.sv -----
// valid/ready channel interfaces for mark/flush items and emitted results
// depends on drt_pkg for the field widths
interface drt_req_if import drt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [COORD_IN_BITS-1:0] rect_left;
	logic [COORD_IN_BITS-1:0] rect_top;
	logic [COORD_IN_BITS-1:0] rect_width;
	logic [COORD_IN_BITS-1:0] rect_height;

	modport source (output valid, kind, rect_left, rect_top, rect_width, rect_height,
		input ready);
	modport sink (input valid, kind, rect_left, rect_top, rect_width, rect_height,
		output ready);
endinterface

interface drt_rsp_if import drt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    entry_valid;
	logic [OUT_POS_BITS-1:0] out_left;
	logic [OUT_POS_BITS-1:0] out_top;
	logic [OUT_DIM_BITS-1:0] out_width;
	logic [OUT_DIM_BITS-1:0] out_height;
	logic                    redraw_all;
	logic [OUT_CNT_BITS-1:0] stored_count;
	logic                    last_result;

	modport source (output valid, entry_valid, out_left, out_top, out_width, out_height,
		redraw_all, stored_count, last_result, input ready);
	modport sink (input valid, entry_valid, out_left, out_top, out_width, out_height,
		redraw_all, stored_count, last_result, output ready);
endinterface

// ----- rtl/dirty_rect_tracker.sv -----
// mark: clip, scan the stored list for an overlap, compaction (each entry against
// every later one, absorbed entries shifted down), then the area sum and threshold compare
// flush: one result per stored rectangle; one item in the memory loop at a time,
// and a stalled result holds the sequencer
// reset clears list count, redraw flag, sequencer and output valid; the store
// itself is not cleared and needs no clearing pass; config resets to 640/480/75
module dirty_rect_tracker import drt_pkg::*; #(
	parameter int MAX_RECTS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	drt_req_if.sink                  req,
	drt_rsp_if.source                rsp
);

	localparam logic [WIDE_BITS-1:0] SCR_LIM = WIDE_BITS'(2 ** COORD_BITS);

	logic [CFG_DIM_BITS-1:0] sw_q, sh_q;
	logic [PCT_BITS-1:0]     pct_q;
	logic [WIDE_BITS-1:0]    sw_x, sh_x;
	logic [COORD_BITS:0]     scr_w, scr_h;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q  <= CFG_DIM_BITS'(640);
			sh_q  <= CFG_DIM_BITS'(480);
			pct_q <= PCT_BITS'(75);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SCREEN_WIDTH:   sw_q  <= cfg_wdata[CFG_DIM_BITS-1:0];
				REG_SCREEN_HEIGHT:  sh_q  <= cfg_wdata[CFG_DIM_BITS-1:0];
				REG_REDRAW_PERCENT: pct_q <= cfg_wdata[PCT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// limit the screen to the coordinate range
	assign sw_x  = WIDE_BITS'(sw_q);
	assign sh_x  = WIDE_BITS'(sh_q);
	assign scr_w = (sw_x > SCR_LIM) ? SCR_LIM[COORD_BITS:0] : sw_x[COORD_BITS:0];
	assign scr_h = (sh_x > SCR_LIM) ? SCR_LIM[COORD_BITS:0] : sh_x[COORD_BITS:0];

	drt_seq #(
		.MAX_RECTS  (MAX_RECTS),
		.COORD_BITS (COORD_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.scr_w  (scr_w),
		.scr_h  (scr_h),
		.pct    (pct_q),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/drt_seq.sv -----
// list sequencer: rectangle memory plus the read-modify-write control that
// scans, merges, compacts, sums areas and flushes; depends on drt_pkg, drt_if
module drt_seq import drt_pkg::*; #(
	parameter int MAX_RECTS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS:0]   scr_w,
	input  logic [COORD_BITS:0]   scr_h,
	input  logic [PCT_BITS-1:0]   pct,
	drt_req_if.sink               req,
	drt_rsp_if.source             rsp
);

	localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int SW = COORD_BITS + 2;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int AW = PW + CW;
	localparam int LW = AW + PCT_BITS;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS:0]   width;
		logic [COORD_BITS:0]   height;
	} box_t;

	seq_state_t st_q, st_d;

	box_t rect_mem_q [MAX_RECTS];
	box_t rd_box_q;
	logic          mem_re, mem_we;
	logic [IW-1:0] mem_ra, mem_wa;
	box_t          mem_wd;

	logic [COORD_IN_BITS-1:0] x_q, y_q, w_q, h_q;
	box_t nb_q, a_q;
	logic [CW-1:0] count_q, i_q, j_q, k_q;
	logic pend_q;
	logic [PW-1:0] prod_q, thr_q;
	logic [AW-1:0] area_q;
	logic [LW-1:0] lhs_q, rhs_q;

	// output register
	logic rsp_vld_q;
	logic out_free, out_load;
	logic out_entry, out_last;
	box_t out_box;
	logic entry_q, redraw_q, last_q;
	logic [OUT_POS_BITS-1:0] left_q, top_q;
	logic [OUT_DIM_BITS-1:0] width_q, height_q;
	logic [OUT_CNT_BITS-1:0] cnt_q;
	logic [OUT_CNT_BITS-1:0] out_cnt;
	logic [7:0] cnt_x;
	logic [WIDE_BITS-1:0] ol_x, ot_x, ow_x, oh_x;

	// clipping of the incoming mark
	logic [WIDE_BITS-1:0] xs, ys, sws, shs, xe, ye, wc, hc;
	logic off_scr, zero_sz;
	box_t clip_box;

	// overlap and bounding box unit
	box_t ab_dst, ab_src, ab_box;
	logic ab_ok;
	logic [SW-1:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, lx, ly, hx, hy;

	logic i_lt, j_lt, k_lt, fl_last;

	assign i_lt    = i_q < count_q;
	assign j_lt    = j_q < count_q;
	assign k_lt    = k_q < count_q;
	assign fl_last = CW'(i_q + 1'b1) == count_q;
	assign out_free = !rsp_vld_q || rsp.ready;

	// rectangle memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) rect_mem_q[mem_wa] <= mem_wd;
		if (mem_re) rd_box_q <= rect_mem_q[mem_ra];
	end

	// clip the mark to the screen
	always_comb begin
		xs = WIDE_BITS'(x_q);
		ys = WIDE_BITS'(y_q);
		sws = WIDE_BITS'(scr_w);
		shs = WIDE_BITS'(scr_h);
		xe = xs + WIDE_BITS'(w_q);
		ye = ys + WIDE_BITS'(h_q);
		off_scr = (xs >= sws) || (ys >= shs);
		wc = (xe > sws) ? (sws - xs) : WIDE_BITS'(w_q);
		hc = (ye > shs) ? (shs - ys) : WIDE_BITS'(h_q);
		zero_sz = (wc == '0) || (hc == '0);
		clip_box.left   = x_q[COORD_BITS-1:0];
		clip_box.top    = y_q[COORD_BITS-1:0];
		clip_box.width  = wc[COORD_BITS:0];
		clip_box.height = hc[COORD_BITS:0];
	end

	// strict overlap test and bounding box
	always_comb begin
		ab_dst = (st_q == S_SCAN_CHK) ? rd_box_q : a_q;
		ab_src = (st_q == S_SCAN_CHK) ? nb_q : rd_box_q;
		ax1 = SW'(ab_dst.left);
		ay1 = SW'(ab_dst.top);
		ax2 = ax1 + SW'(ab_dst.width);
		ay2 = ay1 + SW'(ab_dst.height);
		bx1 = SW'(ab_src.left);
		by1 = SW'(ab_src.top);
		bx2 = bx1 + SW'(ab_src.width);
		by2 = by1 + SW'(ab_src.height);
		ab_ok = !((ax1 >= bx2) || (bx1 >= ax2) || (ay1 >= by2) || (by1 >= ay2));
		lx = (ax1 < bx1) ? ax1 : bx1;
		ly = (ay1 < by1) ? ay1 : by1;
		hx = (ax2 > bx2) ? ax2 : bx2;
		hy = (ay2 > by2) ? ay2 : by2;
		ab_box.left   = lx[COORD_BITS-1:0];
		ab_box.top    = ly[COORD_BITS-1:0];
		ab_box.width  = COORD_BITS'(1'b0) + (COORD_BITS+1)'(hx - lx);
		ab_box.height = COORD_BITS'(1'b0) + (COORD_BITS+1)'(hy - ly);
	end

	// next state, memory control and result load
	always_comb begin
		st_d      = st_q;
		req.ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_ra    = i_q[IW-1:0];
		mem_wa    = i_q[IW-1:0];
		mem_wd    = a_q;
		out_load  = 1'b0;
		out_entry = 1'b0;
		out_last  = 1'b1;
		out_box   = '0;
		out_cnt   = cnt_x[OUT_CNT_BITS-1:0];
		case (st_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) st_d = (req.kind == KIND_FLUSH) ? S_FLUSH : S_CHECK;
			end
			S_CHECK: begin
				st_d = (pend_q || off_scr || zero_sz) ? S_RESP : S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (i_lt) begin
					mem_re = 1'b1;
					st_d = S_SCAN_CHK;
				end else if (count_q < CW'(MAX_RECTS)) begin
					mem_we = 1'b1;
					mem_wa = count_q[IW-1:0];
					mem_wd = nb_q;
					st_d = S_CI;
				end else begin
					st_d = S_RESP;
				end
			end
			S_SCAN_CHK: begin
				if (ab_ok) begin
					mem_we = 1'b1;
					mem_wd = ab_box;
					st_d = S_CI;
				end else begin
					st_d = S_SCAN_RD;
				end
			end
			S_CI: begin
				if (i_lt) begin
					mem_re = 1'b1;
					st_d = S_CI_LD;
				end else begin
					st_d = S_AR;
				end
			end
			S_CI_LD: st_d = S_CJ;
			S_CJ: begin
				if (j_lt) begin
					mem_re = 1'b1;
					mem_ra = j_q[IW-1:0];
					st_d = S_CJ_CHK;
				end else begin
					mem_we = 1'b1;
					st_d = S_CI;
				end
			end
			S_CJ_CHK: st_d = ab_ok ? S_SH : S_CJ;
			S_SH: begin
				if (k_lt) begin
					mem_re = 1'b1;
					mem_ra = k_q[IW-1:0];
					st_d = S_SH_WR;
				end else begin
					st_d = S_CJ;
				end
			end
			S_SH_WR: begin
				mem_we = 1'b1;
				mem_wa = IW'(k_q - 1'b1);
				mem_wd = rd_box_q;
				st_d = S_SH;
			end
			S_AR: begin
				if (i_lt) begin
					mem_re = 1'b1;
					st_d = S_AR_MUL;
				end else begin
					st_d = S_THR;
				end
			end
			S_AR_MUL: st_d = S_AR_ACC;
			S_AR_ACC: st_d = S_AR;
			S_THR:    st_d = S_THR2;
			S_THR2:   st_d = S_CMP;
			S_CMP:    st_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (count_q == '0) begin
					if (out_free) begin
						out_load = 1'b1;
						st_d = S_IDLE;
					end
				end else begin
					st_d = S_FL_RD;
				end
			end
			S_FL_RD: begin
				mem_re = 1'b1;
				st_d = S_FL_OUT;
			end
			S_FL_OUT: begin
				out_entry = 1'b1;
				out_box   = rd_box_q;
				out_last  = fl_last;
				out_cnt   = '0;
				if (out_free) begin
					out_load = 1'b1;
					st_d = fl_last ? S_IDLE : S_FL_RD;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			count_q   <= '0;
			pend_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
			case (st_q)
				S_SCAN_RD: begin
					if (!i_lt) begin
						if (count_q < CW'(MAX_RECTS)) count_q <= count_q + 1'b1;
						else pend_q <= 1'b1;
					end
				end
				S_SH: if (!k_lt) count_q <= count_q - 1'b1;
				S_CMP: if (lhs_q >= rhs_q) pend_q <= 1'b1;
				S_FLUSH: if (count_q == '0 && out_free) pend_q <= 1'b0;
				S_FL_OUT: begin
					if (out_free && fl_last) begin
						count_q <= '0;
						pend_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (req.valid) begin
					x_q <= req.rect_left;
					y_q <= req.rect_top;
					w_q <= req.rect_width;
					h_q <= req.rect_height;
				end
			end
			S_CHECK: begin
				nb_q <= clip_box;
				i_q  <= '0;
			end
			S_SCAN_RD: if (!i_lt) i_q <= '0;
			S_SCAN_CHK: i_q <= ab_ok ? '0 : CW'(i_q + 1'b1);
			S_CI: begin
				if (!i_lt) begin
					i_q    <= '0;
					area_q <= '0;
				end
			end
			S_CI_LD: begin
				a_q <= rd_box_q;
				j_q <= CW'(i_q + 1'b1);
			end
			S_CJ: if (!j_lt) i_q <= CW'(i_q + 1'b1);
			S_CJ_CHK: begin
				if (ab_ok) begin
					a_q <= ab_box;
					k_q <= CW'(j_q + 1'b1);
				end else begin
					j_q <= CW'(j_q + 1'b1);
				end
			end
			S_SH_WR: k_q <= CW'(k_q + 1'b1);
			S_AR_MUL: begin
				prod_q <= PW'(rd_box_q.width) * PW'(rd_box_q.height);
				i_q    <= CW'(i_q + 1'b1);
			end
			S_AR_ACC: area_q <= area_q + AW'(prod_q);
			S_THR: begin
				thr_q <= PW'(scr_w) * PW'(scr_h);
				lhs_q <= LW'(area_q) * LW'(PCT_SCALE);
			end
			S_THR2: rhs_q <= LW'(thr_q) * LW'(pct);
			S_FLUSH: i_q <= '0;
			S_FL_OUT: if (out_free) i_q <= CW'(i_q + 1'b1);
			default: ;
		endcase
	end

	// result payload register
	assign cnt_x = 8'(count_q);
	assign ol_x  = WIDE_BITS'(out_box.left);
	assign ot_x  = WIDE_BITS'(out_box.top);
	assign ow_x  = WIDE_BITS'(out_box.width);
	assign oh_x  = WIDE_BITS'(out_box.height);

	always_ff @(posedge clk) begin
		if (out_load) begin
			entry_q  <= out_entry;
			left_q   <= ol_x[OUT_POS_BITS-1:0];
			top_q    <= ot_x[OUT_POS_BITS-1:0];
			width_q  <= ow_x[OUT_DIM_BITS-1:0];
			height_q <= oh_x[OUT_DIM_BITS-1:0];
			redraw_q <= pend_q;
			cnt_q    <= out_cnt;
			last_q   <= out_last;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.entry_valid  = entry_q;
	assign rsp.out_left     = left_q;
	assign rsp.out_top      = top_q;
	assign rsp.out_width    = width_q;
	assign rsp.out_height   = height_q;
	assign rsp.redraw_all   = redraw_q;
	assign rsp.stored_count = cnt_q;
	assign rsp.last_result  = last_q;

	// checks on the list bookkeeping
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_RECTS) else $error("list count above capacity");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && mem_we) |-> (mem_ra != mem_wa)) else $error("read and write same entry");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (int'(mem_wa) < MAX_RECTS)) else $error("write beyond list");
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FL_OUT && out_free && fl_last) |=> (count_q == '0 && !pend_q))
		else $error("flush did not clear list");

endmodule
